// ----- hdl/aohm_pkg.sv -----
package aohm_pkg;

  localparam int SAMPLE_W     = 23;
  localparam int WANTED_W     = 16;
  localparam int TAKEN_OUT_W  = 16;
  localparam int SUM_OUT_W    = 48;
  localparam int ADD_W        = 32;
  localparam int COUNT_W_DEF  = 16;
  localparam int SUM_W_DEF    = 48;

  typedef enum logic [1:0] {
    RNG_OFF  = 2'd0,
    RNG_10U  = 2'd1,
    RNG_210U = 2'd2,
    RNG_1M   = 2'd3
  } range_t;

  localparam logic CMD_BEGIN  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample_uv;
    logic [WANTED_W-1:0]        samples_wanted;
  } item_t;

  typedef struct packed {
    range_t range;
    logic   changed;
    logic   accept;
  } cal_res_t;

  // range windows, microvolts
  localparam logic signed [SAMPLE_W-1:0] V_LO_10U  = 23'sd45000;
  localparam logic signed [SAMPLE_W-1:0] V_LO_210U = 23'sd200000;
  localparam logic signed [SAMPLE_W-1:0] V_HI_210U = 23'sd1000000;
  localparam logic signed [SAMPLE_W-1:0] V_HI_1M   = 23'sd1100000;

  // Calibration q = floor((A*v + B + D/2) / D), evaluated on the offset-binary
  // sample w = v + 2^22 as q = K + ((w*M + OFS) >> CAL_SHIFT).
  // M and OFS are rounded up so the estimate error stays in [0, 1/D).
  localparam int     CAL_SHIFT = 40;
  localparam int     MUL_W     = 48;
  localparam longint V_OFFSET  = longint'(1) << (SAMPLE_W - 1);
  localparam longint SHIFT_ONE = longint'(1) << CAL_SHIFT;

  localparam longint A10 = 99946;
  localparam longint B10 = -68395910;
  localparam longint D10 = 1000;
  localparam longint C10 = B10 + D10 / 2 - A10 * V_OFFSET;
  localparam longint K10 = (C10 >= 0) ? C10 / D10 : -((-C10 + D10 - 1) / D10);
  localparam longint R10 = C10 - K10 * D10;
  localparam longint M10 = (A10 * SHIFT_ONE + D10 - 1) / D10;
  localparam longint O10 = (R10 * SHIFT_ONE + D10 - 1) / D10;

  localparam longint A210 = 96123;
  localparam longint B210 = 64'sd2268028980;
  localparam longint D210 = 21000;
  localparam longint C210 = B210 + D210 / 2 - A210 * V_OFFSET;
  localparam longint K210 = (C210 >= 0) ? C210 / D210 : -((-C210 + D210 - 1) / D210);
  localparam longint R210 = C210 - K210 * D210;
  localparam longint M210 = (A210 * SHIFT_ONE + D210 - 1) / D210;
  localparam longint O210 = (R210 * SHIFT_ONE + D210 - 1) / D210;

  localparam longint A1M = 12351;
  localparam longint B1M = -69880000;
  localparam longint D1M = 10000;
  localparam longint C1M = B1M + D1M / 2 - A1M * V_OFFSET;
  localparam longint K1M = (C1M >= 0) ? C1M / D1M : -((-C1M + D1M - 1) / D1M);
  localparam longint R1M = C1M - K1M * D1M;
  localparam longint M1M = (A1M * SHIFT_ONE + D1M - 1) / D1M;
  localparam longint O1M = (R1M * SHIFT_ONE + D1M - 1) / D1M;

endpackage

// ----- hdl/aohm_in_reg.sv -----
module aohm_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  aohm_pkg::item_t in_item,
  input  logic           take,
  output logic           item_valid,
  output aohm_pkg::item_t item
);
  import aohm_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- hdl/aohm_calib.sv -----
module aohm_calib (
  input  aohm_pkg::range_t                        range_cur,
  input  logic signed [aohm_pkg::SAMPLE_W-1:0]    sample_uv,
  output aohm_pkg::cal_res_t                      res,
  output logic signed [aohm_pkg::ADD_W-1:0]       addend
);
  import aohm_pkg::*;

  localparam int PROD_W = SAMPLE_W + MUL_W + 1;
  localparam int Q_W    = ADD_W - 1;

  logic [SAMPLE_W-1:0]       w;
  logic [PROD_W-1:0]         p10, p210, p1m;
  logic signed [ADD_W-1:0]   a10, a210, a1m;

  assign w = {~sample_uv[SAMPLE_W-1], sample_uv[SAMPLE_W-2:0]};

  assign p10  = PROD_W'(w) * PROD_W'(MUL_W'(M10))  + PROD_W'(MUL_W'(O10));
  assign p210 = PROD_W'(w) * PROD_W'(MUL_W'(M210)) + PROD_W'(MUL_W'(O210));
  assign p1m  = PROD_W'(w) * PROD_W'(MUL_W'(M1M))  + PROD_W'(MUL_W'(O1M));

  assign a10  = signed'({1'b0, p10[CAL_SHIFT +: Q_W]})  + ADD_W'(K10);
  assign a210 = signed'({1'b0, p210[CAL_SHIFT +: Q_W]}) + ADD_W'(K210);
  assign a1m  = signed'({1'b0, p1m[CAL_SHIFT +: Q_W]})  + ADD_W'(K1M);

  always_comb begin
    res.range   = range_cur;
    res.changed = 1'b0;
    res.accept  = 1'b0;
    addend      = '0;
    unique case (range_cur)
      RNG_10U: begin
        if (sample_uv < V_LO_10U) begin
          res.range   = RNG_210U;
          res.changed = 1'b1;
        end else begin
          res.accept = 1'b1;
          addend     = a10;
        end
      end
      RNG_210U: begin
        if (sample_uv > V_HI_210U) begin
          res.range   = RNG_10U;
          res.changed = 1'b1;
        end else if (sample_uv < V_LO_210U) begin
          res.range   = RNG_1M;
          res.changed = 1'b1;
        end else begin
          res.accept = 1'b1;
          addend     = a210;
        end
      end
      RNG_1M: begin
        if (sample_uv >= V_HI_1M) begin
          res.range   = RNG_210U;
          res.changed = 1'b1;
        end else begin
          res.accept = 1'b1;
          addend     = a1m;
        end
      end
      default: begin
        res.range   = RNG_1M;
        res.changed = 1'b1;
      end
    endcase
  end

endmodule

// ----- hdl/autoranging_ohmmeter_control_core.sv -----
// Autoranging ohmmeter control.
// Input channel (in_valid/in_ready): in_cmd 0 begins a measurement with
// in_samples_wanted samples; in_cmd 1 delivers one ADC reading in_sample_uv.
// Output channel (out_valid/out_ready): one result per input transfer, carrying
// the excitation range now selected, whether the range changed (sample
// dropped), the saturating milliohm sum, the accepted sample count and done.
// A result passes through the input register and then the result register, which
// holds it with out_valid; a stalled receiver can keep the item waiting in the
// input register.
// One item per cycle while the receiver accepts results; the range decision and
// the three constant multiply-adds of the calibration sit between the input and
// result registers. When the receiver stalls, the result register holds and the
// input register takes one more item; in_ready then drops until out_ready returns.
// Reset (rst_n low, synchronous) turns excitation off, clears the sum and
// counts, leaves the block idle and empties both registers.
module autoranging_ohmmeter_control_core #(
  parameter int COUNT_WIDTH = aohm_pkg::COUNT_W_DEF,
  parameter int SUM_WIDTH   = aohm_pkg::SUM_W_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_cmd,
  input  logic signed [aohm_pkg::SAMPLE_W-1:0]    in_sample_uv,
  input  logic [aohm_pkg::WANTED_W-1:0]           in_samples_wanted,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [1:0]                              out_range_code,
  output logic                                    out_range_changed,
  output logic signed [aohm_pkg::SUM_OUT_W-1:0]   out_sum_mohm,
  output logic [aohm_pkg::TAKEN_OUT_W-1:0]        out_samples_taken,
  output logic                                    out_done_res
);
  import aohm_pkg::*;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  item_t    in_item, item;
  logic     item_valid, take, fire;
  cal_res_t cal;
  logic signed [ADD_W-1:0] addend;

  range_t                       range_r, range_nxt;
  logic signed [SUM_WIDTH-1:0]  sum_r, sum_nxt, sum_sat;
  logic signed [SUM_WIDTH:0]    sum_ext;
  logic [COUNT_WIDTH-1:0]       taken_r, taken_nxt, target_r, target_nxt;
  logic                         meas_r, meas_nxt;
  logic                         changed_nxt, done_nxt;

  logic                         out_valid_r;
  range_t                       out_range_r;
  logic                         out_changed_r, out_done_r;
  logic signed [SUM_OUT_W-1:0]  out_sum_r;
  logic [TAKEN_OUT_W-1:0]       out_taken_r;

  assign in_item.cmd            = in_cmd;
  assign in_item.sample_uv      = in_sample_uv;
  assign in_item.samples_wanted = in_samples_wanted;

  assign take = !out_valid_r || out_ready;
  assign fire = item_valid && take;

  aohm_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  aohm_calib u_calib (
    .range_cur (range_r),
    .sample_uv (item.sample_uv),
    .res       (cal),
    .addend    (addend)
  );

  assign sum_ext = (SUM_WIDTH+1)'(sum_r) + (SUM_WIDTH+1)'(addend);
  assign sum_sat = (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) ?
                   (sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX) : sum_ext[SUM_WIDTH-1:0];

  always_comb begin
    range_nxt   = range_r;
    sum_nxt     = sum_r;
    taken_nxt   = taken_r;
    target_nxt  = target_r;
    meas_nxt    = meas_r;
    changed_nxt = 1'b0;
    done_nxt    = 1'b0;
    if (item.cmd == CMD_BEGIN) begin
      target_nxt = COUNT_WIDTH'(item.samples_wanted);
      sum_nxt    = '0;
      taken_nxt  = '0;
      if (target_nxt == '0) begin
        meas_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        meas_nxt = 1'b1;
        if (range_r == RNG_OFF) begin
          range_nxt   = RNG_1M;
          changed_nxt = 1'b1;
        end
      end
    end else if (meas_r) begin
      range_nxt   = cal.range;
      changed_nxt = cal.changed;
      if (cal.accept) begin
        sum_nxt   = sum_sat;
        taken_nxt = taken_r + COUNT_WIDTH'(1);
        if (taken_nxt == target_r) begin
          done_nxt = 1'b1;
          meas_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r     <= RNG_OFF;
      sum_r       <= '0;
      taken_r     <= '0;
      target_r    <= '0;
      meas_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      range_r       <= range_nxt;
      sum_r         <= sum_nxt;
      taken_r       <= taken_nxt;
      target_r      <= target_nxt;
      meas_r        <= meas_nxt;
      out_valid_r   <= 1'b1;
      out_range_r   <= range_nxt;
      out_changed_r <= changed_nxt;
      out_done_r    <= done_nxt;
      out_sum_r     <= SUM_OUT_W'(sum_nxt);
      out_taken_r   <= TAKEN_OUT_W'(taken_nxt);
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_range_code    = out_range_r;
  assign out_range_changed = out_changed_r;
  assign out_sum_mohm      = out_sum_r;
  assign out_samples_taken = out_taken_r;
  assign out_done_res      = out_done_r;

  a_meas_has_range: assert property (@(posedge clk) disable iff (!rst_n)
    meas_r |-> (range_r != RNG_OFF))
    else $error("measuring with excitation off");

  a_done_ends_meas: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && done_nxt) |=> !meas_r)
    else $error("measurement still active after done");

  a_change_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_changed_r && out_done_r))
    else $error("range change reported together with done");

  a_change_has_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_changed_r) |-> (out_range_r != RNG_OFF))
    else $error("range change to excitation off");

endmodule
